// ===== rtl/core/sted_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sted_pkg;

  localparam int unsigned QueueDepth  = 32;
  localparam int unsigned OwnerWidth  = 8;
  localparam int unsigned MaxResults  = 32;
  localparam int unsigned TimeWidth   = 32;
  localparam int unsigned TagWidth    = 32;

  typedef enum logic [1:0] {
    REQ_ADD       = 2'd0,
    REQ_REMOVE    = 2'd1,
    REQ_REMOVE_ALL = 2'd2,
    REQ_TICK      = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_FIRED   = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_NOTHING = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_REM_RD,
    ST_REM_WR,
    ST_TICK_CHK,
    ST_TICK_HEAD,
    ST_TICK_NEXT
  } state_e;

endpackage
`default_nettype wire

// ===== rtl/core/sted_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sted_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AddrWidth-1:0] waddr_i,
  input  wire logic [Width-1:0]     wdata_i,
  input  wire logic [AddrWidth-1:0] raddr_i,
  output logic      [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/core/sorted_timed_event_queue_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Time-ordered event queue held in one single-port-read RAM used as a ring. A command is
// taken when start_i is high and busy_o is low; every result appears for exactly one cycle
// with valid_o high and must be captured then, since the block cannot be stalled. An add
// walks from the tail toward the head, reading each entry it moves in ST_ADD_RD and
// writing it one slot further on in ST_ADD_WR; an add to a full queue answers without
// going busy. A remove compacts the whole queue; a tick checks the head, then fires each
// due event from the head in turn. Each result is registered and appears in the cycle
// after the step that produces it. The RAM's read is registered and it has a single
// read port, which sets this read-then-write order.
module sorted_timed_event_queue_top #(
  parameter int unsigned QUEUE_DEPTH = sted_pkg::QueueDepth,
  parameter int unsigned OWNER_WIDTH = sted_pkg::OwnerWidth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [1:0]         req_type_i,
  input  wire logic [7:0]         owner_id_i,
  input  wire logic signed [31:0] delay_i,
  input  wire logic signed [31:0] tag_i,
  input  wire logic [31:0]        current_time_i,
  output logic                    valid_o,
  output logic [1:0]              status_o,
  output logic [7:0]              fired_owner_o,
  output logic signed [31:0]      fired_tag_o,
  output logic [5:0]              removed_count_o,
  output logic [31:0]             next_due_time_o,
  output logic                    queue_empty_o,
  output logic                    last_o
);

  localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TW = sted_pkg::TimeWidth;
  localparam int unsigned GW = sted_pkg::TagWidth;
  localparam int unsigned EW = TW + OWNER_WIDTH + GW;
  localparam int unsigned NW = $clog2(sted_pkg::MaxResults + 1);

  sted_pkg::state_e state_q, state_d;

  logic [CW-1:0]          fill_q, fill_d;
  logic [IW-1:0]          head_q, head_d;
  logic [TW-1:0]          head_due_q, head_due_d;
  logic [CW-1:0]          idx_q, idx_d;
  logic [CW-1:0]          wr_q, wr_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [NW-1:0]          n_q, n_d;
  logic [1:0]             req_q, req_d;
  logic [OWNER_WIDTH-1:0] owner_q, owner_d;
  logic [TW-1:0]          due_q, due_d;
  logic [GW-1:0]          tag_q, tag_d;
  logic [TW-1:0]          now_q, now_d;
  logic [OWNER_WIDTH-1:0] fo_q, fo_d;
  logic [GW-1:0]          ft_q, ft_d;

  logic                   valid_q, valid_d;
  logic [1:0]             status_q, status_d;
  logic [7:0]             fowner_q, fowner_d;
  logic [GW-1:0]          ftag_q, ftag_d;
  logic [5:0]             rcount_q, rcount_d;
  logic [TW-1:0]          ndue_q, ndue_d;
  logic                   empty_q, empty_d;
  logic                   last_q, last_d;

  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  logic [TW-1:0]          rd_due;
  logic [OWNER_WIDTH-1:0] rd_owner;
  logic [GW-1:0]          rd_tag;
  logic                   start_ok, full, head_due_now, rem_hit, tick_more;
  logic [EW-1:0]          new_entry;

  function automatic logic [IW-1:0] phys(input logic [IW-1:0] head,
                                         input logic [CW-1:0] l);
    logic [IW:0] s;
    s = (IW+1)'(head) + (IW+1)'(l);
    if (s >= (IW+1)'(QUEUE_DEPTH)) begin
      s = s - (IW+1)'(QUEUE_DEPTH);
    end
    return s[IW-1:0];
  endfunction

  function automatic logic [5:0] sat6(input logic [CW-1:0] v);
    logic [CW+5:0] w;
    w = (CW+6)'(v);
    return (w > (CW+6)'(63)) ? 6'd63 : w[5:0];
  endfunction

  sted_ram #(
    .Width(EW),
    .Depth(QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_due    = ram_rdata[EW-1 -: TW];
  assign rd_owner  = ram_rdata[GW +: OWNER_WIDTH];
  assign rd_tag    = ram_rdata[GW-1:0];
  assign new_entry = {due_q, owner_q, tag_q};

  assign start_ok     = start_i && (state_q == sted_pkg::ST_IDLE);
  assign full         = (fill_q == CW'(QUEUE_DEPTH));
  assign head_due_now = (fill_q != '0) && (head_due_q <= now_q);
  assign rem_hit      = (rd_owner == owner_q) &&
                        ((req_q == sted_pkg::REQ_REMOVE_ALL) || (rd_tag == tag_q));
  assign tick_more    = ((NW+1)'(n_q) + (NW+1)'(1) < (NW+1)'(sted_pkg::MaxResults)) &&
                        (fill_q != '0) && (rd_due <= now_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      sted_pkg::ST_IDLE: begin
        if (start_ok) begin
          case (req_type_i)
            sted_pkg::REQ_ADD:        state_d = full ? sted_pkg::ST_IDLE : sted_pkg::ST_ADD_RD;
            sted_pkg::REQ_REMOVE,
            sted_pkg::REQ_REMOVE_ALL: state_d = sted_pkg::ST_REM_RD;
            default:                  state_d = sted_pkg::ST_TICK_CHK;
          endcase
        end
      end
      sted_pkg::ST_ADD_RD: begin
        state_d = (idx_q == '0) ? sted_pkg::ST_IDLE : sted_pkg::ST_ADD_WR;
      end
      sted_pkg::ST_ADD_WR: begin
        state_d = (rd_due > due_q) ? sted_pkg::ST_ADD_RD : sted_pkg::ST_IDLE;
      end
      sted_pkg::ST_REM_RD: begin
        state_d = (idx_q == fill_q) ? sted_pkg::ST_IDLE : sted_pkg::ST_REM_WR;
      end
      sted_pkg::ST_REM_WR: begin
        state_d = sted_pkg::ST_REM_RD;
      end
      sted_pkg::ST_TICK_CHK: begin
        state_d = head_due_now ? sted_pkg::ST_TICK_HEAD : sted_pkg::ST_IDLE;
      end
      sted_pkg::ST_TICK_HEAD: begin
        state_d = sted_pkg::ST_TICK_NEXT;
      end
      sted_pkg::ST_TICK_NEXT: begin
        state_d = tick_more ? sted_pkg::ST_TICK_HEAD : sted_pkg::ST_IDLE;
      end
      default: state_d = sted_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    fill_d     = fill_q;
    head_d     = head_q;
    head_due_d = head_due_q;
    idx_d      = idx_q;
    wr_d       = wr_q;
    cnt_d      = cnt_q;
    n_d        = n_q;
    req_d      = req_q;
    owner_d    = owner_q;
    due_d      = due_q;
    tag_d      = tag_q;
    now_d      = now_q;
    fo_d       = fo_q;
    ft_d       = ft_q;
    ram_we     = 1'b0;
    ram_waddr  = head_q;
    ram_wdata  = new_entry;
    ram_raddr  = head_q;
    valid_d    = 1'b0;
    status_d   = sted_pkg::STAT_DONE;
    fowner_d   = '0;
    ftag_d     = '0;
    rcount_d   = '0;
    last_d     = 1'b1;
    case (state_q)
      sted_pkg::ST_IDLE: begin
        if (start_ok) begin
          req_d   = req_type_i;
          owner_d = OWNER_WIDTH'(owner_id_i);
          due_d   = current_time_i + $unsigned(delay_i);
          tag_d   = $unsigned(tag_i);
          now_d   = current_time_i;
          idx_d   = (req_type_i == sted_pkg::REQ_ADD) ? fill_q : '0;
          wr_d    = '0;
          cnt_d   = '0;
          n_d     = '0;
          if ((req_type_i == sted_pkg::REQ_ADD) && full) begin
            valid_d  = 1'b1;
            status_d = sted_pkg::STAT_FULL;
          end
        end
      end
      sted_pkg::ST_ADD_RD: begin
        if (idx_q == '0) begin
          ram_we     = 1'b1;
          ram_waddr  = phys(head_q, '0);
          head_due_d = due_q;
          fill_d     = fill_q + CW'(1);
          valid_d    = 1'b1;
        end else begin
          ram_raddr = phys(head_q, idx_q - CW'(1));
        end
      end
      sted_pkg::ST_ADD_WR: begin
        ram_we    = 1'b1;
        ram_waddr = phys(head_q, idx_q);
        if (rd_due > due_q) begin
          ram_wdata = ram_rdata;
          idx_d     = idx_q - CW'(1);
        end else begin
          fill_d  = fill_q + CW'(1);
          valid_d = 1'b1;
        end
      end
      sted_pkg::ST_REM_RD: begin
        if (idx_q == fill_q) begin
          fill_d   = wr_q;
          valid_d  = 1'b1;
          rcount_d = sat6(cnt_q);
        end else begin
          ram_raddr = phys(head_q, idx_q);
        end
      end
      sted_pkg::ST_REM_WR: begin
        idx_d = idx_q + CW'(1);
        if (rem_hit) begin
          cnt_d = cnt_q + CW'(1);
        end else begin
          ram_we    = 1'b1;
          ram_waddr = phys(head_q, wr_q);
          ram_wdata = ram_rdata;
          wr_d      = wr_q + CW'(1);
          if (wr_q == '0) begin
            head_due_d = rd_due;
          end
        end
      end
      sted_pkg::ST_TICK_CHK: begin
        if (!head_due_now) begin
          valid_d  = 1'b1;
          status_d = sted_pkg::STAT_NOTHING;
        end
      end
      sted_pkg::ST_TICK_HEAD: begin
        fo_d      = rd_owner;
        ft_d      = rd_tag;
        ram_raddr = phys(head_q, CW'(1));
        head_d    = phys(head_q, CW'(1));
        fill_d    = fill_q - CW'(1);
      end
      sted_pkg::ST_TICK_NEXT: begin
        if (fill_q != '0) begin
          head_due_d = rd_due;
        end
        n_d      = n_q + NW'(1);
        valid_d  = 1'b1;
        status_d = sted_pkg::STAT_FIRED;
        fowner_d = 8'(fo_q);
        ftag_d   = ft_q;
        last_d   = !tick_more;
      end
      default: begin
      end
    endcase
    ndue_d  = (fill_d != '0) ? head_due_d : '0;
    empty_d = (fill_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sted_pkg::ST_IDLE;
      fill_q  <= '0;
      head_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      head_q  <= head_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_due_q <= head_due_d;
    idx_q      <= idx_d;
    wr_q       <= wr_d;
    cnt_q      <= cnt_d;
    n_q        <= n_d;
    req_q      <= req_d;
    owner_q    <= owner_d;
    due_q      <= due_d;
    tag_q      <= tag_d;
    now_q      <= now_d;
    fo_q       <= fo_d;
    ft_q       <= ft_d;
    status_q   <= status_d;
    fowner_q   <= fowner_d;
    ftag_q     <= ftag_d;
    rcount_q   <= rcount_d;
    ndue_q     <= ndue_d;
    empty_q    <= empty_d;
    last_q     <= last_d;
  end

  assign busy_o          = (state_q != sted_pkg::ST_IDLE);
  assign valid_o         = valid_q;
  assign status_o        = status_q;
  assign fired_owner_o   = fowner_q;
  assign fired_tag_o     = $signed(ftag_q);
  assign removed_count_o = rcount_q;
  assign next_due_time_o = ndue_q;
  assign queue_empty_o   = empty_q;
  assign last_o          = last_q;

endmodule
`default_nettype wire
